// File: rtl/fdpm_pkg.sv
// Shared types and constants for the frame deframer with pending request table.
// Used by every module of the block; no dependencies.
`default_nettype none

package fdpm_pkg;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_HEAD_BYTE      = 3'd0;
    localparam logic [2:0] REG_HEADER_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_BODY_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_ENTRY_EXPIRY   = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH     = 3'd4;

    localparam logic [7:0] CODE_RESP_BIT = 8'h80;
    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_REQ  = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EV_OK        = 3'd0,
        EV_BAD_CHECK = 3'd1,
        EV_STORED    = 3'd2,
        EV_REFUSED   = 3'd3,
        EV_TICK      = 3'd4,
        EV_TOO_LONG  = 3'd5
    } ev_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SEQ  = 3'd1,
        PH_CODE = 3'd2,
        PH_LENH = 3'd3,
        PH_LENL = 3'd4,
        PH_BODY = 3'd5,
        PH_CHK  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_START = 2'd1,
        ST_SCAN  = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [15:0] header_timeout;
        logic [15:0] body_timeout;
        logic [15:0] entry_expiry;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic go_scan;
        logic go_emit;
        logic scan_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        ev_t         ev;
        logic [7:0]  seq;
        logic [6:0]  code;
        logic [15:0] len;
        logic        matched;
        logic [2:0]  slot;
        logic [7:0]  rx_check;
        logic [7:0]  calc_check;
        logic        abandoned;
        logic [3:0]  expired;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/fdpm_regs.sv
// APB configuration registers of the deframer.
// Depends on fdpm_pkg.
`default_nettype none

module fdpm_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fdpm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output fdpm_pkg::cfg_t                     cfg
);

    logic [7:0]  head_byte_reg;
    logic [15:0] header_timeout_reg;
    logic [15:0] body_timeout_reg;
    logic [15:0] entry_expiry_reg;
    logic [15:0] max_length_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_byte_reg      <= 8'd201;
            header_timeout_reg <= 16'd500;
            body_timeout_reg   <= 16'd1000;
            entry_expiry_reg   <= 16'd60000;
            max_length_reg     <= 16'd1018;
        end else if (wr_en) begin
            unique case (reg_idx)
                fdpm_pkg::REG_HEAD_BYTE:      head_byte_reg      <= pwdata[7:0];
                fdpm_pkg::REG_HEADER_TIMEOUT: header_timeout_reg <= pwdata[15:0];
                fdpm_pkg::REG_BODY_TIMEOUT:   body_timeout_reg   <= pwdata[15:0];
                fdpm_pkg::REG_ENTRY_EXPIRY:   entry_expiry_reg   <= pwdata[15:0];
                fdpm_pkg::REG_MAX_LENGTH:     max_length_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fdpm_pkg::REG_HEAD_BYTE:      prdata = {24'd0, head_byte_reg};
            fdpm_pkg::REG_HEADER_TIMEOUT: prdata = {16'd0, header_timeout_reg};
            fdpm_pkg::REG_BODY_TIMEOUT:   prdata = {16'd0, body_timeout_reg};
            fdpm_pkg::REG_ENTRY_EXPIRY:   prdata = {16'd0, entry_expiry_reg};
            fdpm_pkg::REG_MAX_LENGTH:     prdata = {16'd0, max_length_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign cfg.head_byte      = head_byte_reg;
    assign cfg.header_timeout = header_timeout_reg;
    assign cfg.body_timeout   = body_timeout_reg;
    assign cfg.entry_expiry   = entry_expiry_reg;
    assign cfg.max_length     = max_length_reg;

endmodule

`default_nettype wire

// File: rtl/fdpm_ctrl.sv
// Controller state machine: takes an item, starts it, walks the slot scan, emits.
// Depends on fdpm_pkg.
`default_nettype none

module fdpm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  fdpm_pkg::status_t      status,
    output fdpm_pkg::cmd_t         cmd
);

    fdpm_pkg::state_t state_reg;
    fdpm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fdpm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fdpm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = fdpm_pkg::ST_START;
                end
            end
            fdpm_pkg::ST_START: begin
                cmd.start = 1'b1;
                if (status.go_scan) begin
                    state_next = fdpm_pkg::ST_SCAN;
                end else if (status.go_emit) begin
                    state_next = fdpm_pkg::ST_EMIT;
                end else begin
                    state_next = fdpm_pkg::ST_IDLE;
                end
            end
            fdpm_pkg::ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.scan_done) begin
                    state_next = fdpm_pkg::ST_EMIT;
                end
            end
            fdpm_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = fdpm_pkg::ST_IDLE;
                end
            end
            default: state_next = fdpm_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/fdpm_dp.sv
// Datapath: item latch, frame parser registers, request slot table, result staging
// and output register. Depends on fdpm_pkg.
`default_nettype none

module fdpm_dp #(
    parameter int SLOTS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  fdpm_pkg::cfg_t         cfg,
    input  fdpm_pkg::cmd_t         cmd,
    output fdpm_pkg::status_t      status,
    input  wire logic [1:0]        in_kind,
    input  wire logic [7:0]        in_data_byte,
    input  wire logic [7:0]        in_req_seq,
    input  wire logic [7:0]        in_req_code,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fdpm_pkg::res_t         m_res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // item latch
    fdpm_pkg::kind_t kind_reg;
    logic [7:0]      byte_reg;
    logic [7:0]      rseq_reg;
    logic [7:0]      rcode_reg;

    // parser
    fdpm_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  fseq_reg, fseq_next;
    logic [7:0]  fcode_reg, fcode_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  chk_reg, chk_next;
    logic [15:0] timer_reg, timer_next;

    // slot table
    logic [7:0]  slot_seq_reg  [SLOTS];
    logic [7:0]  slot_code_reg [SLOTS];
    logic [15:0] slot_age_reg  [SLOTS];

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] exp_reg, exp_next;

    fdpm_pkg::res_t res_reg, res_next;
    fdpm_pkg::res_t out_reg;
    logic           m_valid_reg, m_valid_next;

    logic        code_we, seq_we, age_we;
    logic [7:0]  code_wval;
    logic [15:0] age_wval;

    logic [15:0] new_len;
    logic [7:0]  cur_code, cur_seq;
    logic [15:0] cur_age, age_inc;
    logic        slot_exp, hit_match, hit_free, scan_last;
    logic [15:0] idx_wide, exp_wide;
    logic [CNT_W-1:0] exp_total;
    logic [15:0] timer_inc, limit;
    logic        drop;
    logic        chk_ok;

    assign new_len   = {flen_reg[15:8], byte_reg};
    assign chk_ok    = (byte_reg == chk_reg);
    assign cur_code  = slot_code_reg[idx_reg];
    assign cur_seq   = slot_seq_reg[idx_reg];
    assign cur_age   = slot_age_reg[idx_reg];
    assign age_inc   = (cur_age != fdpm_pkg::SAT16) ? cur_age + 16'd1 : cur_age;
    assign slot_exp  = (cur_code != 8'd0) && (age_inc > cfg.entry_expiry);
    assign hit_match = (cur_code != 8'd0) && (cur_seq == fseq_reg)
                       && (fcode_reg == (cur_code | fdpm_pkg::CODE_RESP_BIT));
    assign hit_free  = (cur_code == 8'd0);
    assign scan_last = (idx_reg == IDX_W'(SLOTS - 1));
    assign idx_wide  = 16'(idx_reg);
    assign exp_total = exp_reg + CNT_W'(slot_exp);
    assign exp_wide  = 16'(exp_total);
    assign timer_inc = (timer_reg != fdpm_pkg::SAT16) ? timer_reg + 16'd1 : timer_reg;
    assign limit     = (phase_reg == fdpm_pkg::PH_BODY || phase_reg == fdpm_pkg::PH_CHK)
                       ? cfg.body_timeout : cfg.header_timeout;
    assign drop      = (phase_reg != fdpm_pkg::PH_HUNT) && (timer_inc > limit);

    // controller status
    always_comb begin
        status          = '0;
        status.out_free = !m_valid_reg || m_ready;
        case (kind_reg)
            fdpm_pkg::KIND_BYTE: begin
                status.go_scan   = (phase_reg == fdpm_pkg::PH_CHK) && chk_ok;
                status.go_emit   = ((phase_reg == fdpm_pkg::PH_CHK) && !chk_ok)
                                   || ((phase_reg == fdpm_pkg::PH_LENL)
                                       && (new_len > cfg.max_length));
                status.scan_done = hit_match || scan_last;
            end
            fdpm_pkg::KIND_REQ: begin
                status.go_scan   = (rcode_reg != 8'd0);
                status.go_emit   = (rcode_reg == 8'd0);
                status.scan_done = hit_free || scan_last;
            end
            fdpm_pkg::KIND_TICK: begin
                status.go_scan   = 1'b1;
                status.scan_done = scan_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        fseq_next  = fseq_reg;
        fcode_next = fcode_reg;
        flen_next  = flen_reg;
        left_next  = left_reg;
        chk_next   = chk_reg;
        timer_next = timer_reg;
        idx_next   = idx_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        code_we    = 1'b0;
        code_wval  = 8'd0;
        seq_we     = 1'b0;
        age_we     = 1'b0;
        age_wval   = 16'd0;

        if (cmd.start) begin
            idx_next = '0;
            exp_next = '0;
            case (kind_reg)
                fdpm_pkg::KIND_BYTE: begin
                    unique case (phase_reg)
                        fdpm_pkg::PH_HUNT: begin
                            if (byte_reg == cfg.head_byte) begin
                                chk_next   = byte_reg;
                                timer_next = 16'd0;
                                phase_next = fdpm_pkg::PH_SEQ;
                            end
                        end
                        fdpm_pkg::PH_SEQ: begin
                            fseq_next  = byte_reg;
                            chk_next   = chk_reg ^ byte_reg;
                            phase_next = fdpm_pkg::PH_CODE;
                        end
                        fdpm_pkg::PH_CODE: begin
                            fcode_next = byte_reg;
                            chk_next   = chk_reg ^ byte_reg;
                            phase_next = fdpm_pkg::PH_LENH;
                        end
                        fdpm_pkg::PH_LENH: begin
                            flen_next  = {byte_reg, 8'd0};
                            chk_next   = chk_reg ^ byte_reg;
                            phase_next = fdpm_pkg::PH_LENL;
                        end
                        fdpm_pkg::PH_LENL: begin
                            flen_next = new_len;
                            chk_next  = chk_reg ^ byte_reg;
                            if (new_len > cfg.max_length) begin
                                phase_next   = fdpm_pkg::PH_HUNT;
                                res_next     = '0;
                                res_next.ev  = fdpm_pkg::EV_TOO_LONG;
                                res_next.seq = fseq_reg;
                                res_next.code = fcode_reg[6:0];
                                res_next.len = new_len;
                            end else begin
                                left_next  = new_len;
                                timer_next = 16'd0;
                                phase_next = (new_len != 16'd0) ? fdpm_pkg::PH_BODY
                                                                : fdpm_pkg::PH_CHK;
                            end
                        end
                        fdpm_pkg::PH_BODY: begin
                            chk_next  = chk_reg ^ byte_reg;
                            left_next = left_reg - 16'd1;
                            if (left_reg == 16'd1) begin
                                phase_next = fdpm_pkg::PH_CHK;
                            end
                        end
                        fdpm_pkg::PH_CHK: begin
                            phase_next          = fdpm_pkg::PH_HUNT;
                            res_next            = '0;
                            res_next.ev         = chk_ok ? fdpm_pkg::EV_OK
                                                         : fdpm_pkg::EV_BAD_CHECK;
                            res_next.seq        = fseq_reg;
                            res_next.code       = fcode_reg[6:0];
                            res_next.len        = flen_reg;
                            res_next.rx_check   = byte_reg;
                            res_next.calc_check = chk_reg;
                        end
                        default: phase_next = fdpm_pkg::PH_HUNT;
                    endcase
                end
                fdpm_pkg::KIND_REQ: begin
                    if (rcode_reg == 8'd0) begin
                        res_next     = '0;
                        res_next.ev  = fdpm_pkg::EV_REFUSED;
                        res_next.seq = rseq_reg;
                    end
                end
                default: ;
            endcase
        end else if (cmd.step) begin
            idx_next = idx_reg + IDX_W'(1);
            case (kind_reg)
                fdpm_pkg::KIND_BYTE: begin
                    if (hit_match) begin
                        code_we          = 1'b1;
                        res_next.matched = 1'b1;
                        res_next.slot    = idx_wide[2:0];
                    end
                end
                fdpm_pkg::KIND_REQ: begin
                    if (hit_free) begin
                        code_we       = 1'b1;
                        code_wval     = rcode_reg;
                        seq_we        = 1'b1;
                        age_we        = 1'b1;
                        res_next      = '0;
                        res_next.ev   = fdpm_pkg::EV_STORED;
                        res_next.seq  = rseq_reg;
                        res_next.slot = idx_wide[2:0];
                    end else if (scan_last) begin
                        res_next     = '0;
                        res_next.ev  = fdpm_pkg::EV_REFUSED;
                        res_next.seq = rseq_reg;
                    end
                end
                fdpm_pkg::KIND_TICK: begin
                    if (cur_code != 8'd0) begin
                        age_we   = 1'b1;
                        age_wval = slot_exp ? 16'd0 : age_inc;
                        code_we  = slot_exp;
                    end
                    exp_next = exp_total;
                    if (scan_last) begin
                        res_next           = '0;
                        res_next.ev        = fdpm_pkg::EV_TICK;
                        res_next.abandoned = drop;
                        res_next.expired   = exp_wide[3:0];
                        if (phase_reg != fdpm_pkg::PH_HUNT) begin
                            timer_next = timer_inc;
                        end
                        if (drop) begin
                            phase_next = fdpm_pkg::PH_HUNT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fdpm_pkg::PH_HUNT;
            fseq_reg    <= 8'd0;
            fcode_reg   <= 8'd0;
            flen_reg    <= 16'd0;
            left_reg    <= 16'd0;
            chk_reg     <= 8'd0;
            timer_reg   <= 16'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_code_reg[i] <= 8'd0;
            end
        end else begin
            phase_reg   <= phase_next;
            fseq_reg    <= fseq_next;
            fcode_reg   <= fcode_next;
            flen_reg    <= flen_next;
            left_reg    <= left_next;
            chk_reg     <= chk_next;
            timer_reg   <= timer_next;
            m_valid_reg <= m_valid_next;
            if (code_we) begin
                slot_code_reg[idx_reg] <= code_wval;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= fdpm_pkg::kind_t'(in_kind);
            byte_reg  <= in_data_byte;
            rseq_reg  <= in_req_seq;
            rcode_reg <= in_req_code;
        end
        if (seq_we) begin
            slot_seq_reg[idx_reg] <= rseq_reg;
        end
        if (age_we) begin
            slot_age_reg[idx_reg] <= age_wval;
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
        end
        idx_reg <= idx_next;
        exp_reg <= exp_next;
        res_reg <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

endmodule

`default_nettype wire

// File: rtl/frame_deframer_with_pending_match_unit.sv
// Flow: an item is accepted in idle, then started; a byte that ends no frame is then done.
// A check byte, too-long length, request or tick then goes to emit, first walking the slots
// one slot a cycle through the table read port (no walk for a bad check, a too-long length
// or a zero code); its result is then loaded in the emit state, shown on m_tvalid next.
// A new item is accepted only once the last is done; emit waits while a result is stalled.
// Reset: synchronous, active low; parser hunts, all slots free, registers at defaults.
`default_nettype none

module frame_deframer_with_pending_match_unit #(
    parameter int SLOTS = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,   // data_byte, req_seq, req_code
    input  wire logic [1:0]                   s_tuser,   // kind
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // seq_out, response_code, payload_length, matched, slot, received_check,
    // computed_check, frame_abandoned, expired_count
    output logic [55:0]                       m_tdata,
    output logic [2:0]                        m_tuser,   // event_res
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fdpm_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    fdpm_pkg::cfg_t    cfg;
    fdpm_pkg::cmd_t    cmd;
    fdpm_pkg::status_t status;
    fdpm_pkg::res_t    res;

    fdpm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fdpm_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .in_kind      (s_tuser),
        .in_data_byte (s_tdata[7:0]),
        .in_req_seq   (s_tdata[15:8]),
        .in_req_code  (s_tdata[23:16]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_res        (res)
    );

    assign m_tuser = res.ev;
    assign m_tdata = {res.expired, res.abandoned, res.calc_check, res.rx_check,
                      res.slot, res.matched, res.len, res.code, res.seq};

endmodule

`default_nettype wire

// File: rtl/fdpm_checker.sv
// Port-level checks for the deframer top level, bound to it below.
// Depends on fdpm_pkg and frame_deframer_with_pending_match_unit.
`default_nettype none

module fdpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous still in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_tick_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == fdpm_pkg::EV_TICK) |-> (m_tdata[50:0] == 51'd0))
        else $error("tick result carries frame fields");

    a_match_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31] |-> (m_tuser == fdpm_pkg::EV_OK))
        else $error("match flagged on a non-ok result");

endmodule

bind frame_deframer_with_pending_match_unit fdpm_checker u_fdpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
